>>> sv/chull_pkg.sv
// shared types for the convex hull block
package chull_pkg;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } mac_op_t;

endpackage

>>> sv/chull_pt_if.sv
// input point channel
interface chull_pt_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         final_point;

    modport source (output valid, output point_x, output point_y, output final_point,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input final_point,
                  output ready);
endinterface

>>> sv/chull_hull_if.sv
// output hull vertex channel
interface chull_hull_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] hull_x;
    logic signed [COORD_BITS-1:0] hull_y;
    logic                         hull_last;

    modport source (output valid, output hull_x, output hull_y, output hull_last,
                    input ready);
    modport sink (input valid, input hull_x, input hull_y, input hull_last,
                  output ready);
endinterface

>>> sv/chull_mac.sv
// shared multiply-accumulate unit for cross products and squared lengths
module chull_mac
    import chull_pkg::*;
#(
    parameter int OPW = 17,
    parameter int AW  = 35
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mac_op_t               op,
    input  logic signed [OPW-1:0] a,
    input  logic signed [OPW-1:0] b,
    output logic signed [AW-1:0]  acc
);
    logic signed [2*OPW-1:0] prod;
    logic signed [AW-1:0]    prod_ext;
    logic signed [AW-1:0]    acc_reg;
    logic signed [AW-1:0]    acc_next;

    assign prod     = a * b;
    assign prod_ext = AW'(prod);

    always_comb
    begin
        unique case (op)
            MAC_LOAD: acc_next = prod_ext;
            MAC_ADD:  acc_next = acc_reg + prod_ext;
            MAC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;
endmodule

>>> sv/convex_hull_graham_scan_top.sv
// graham scan convex hull: point store, insertion sort by angle, hull scan, vertex output
// loading: points load one per cycle while idle; after the final point the insertion sort
//   by angle (O(n^2) comparisons) runs, then the hull scan over candidates with its pops
// throughput: one point set at a time, all products run through one shared mac unit
// output: each vertex steps through ST_E1 to ST_E4, plus any wait on hull.ready
// reset: asynchronous active low, clears control state; memories are not cleared
module convex_hull_graham_scan_top
    import chull_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    chull_pt_if.sink     pts,
    chull_hull_if.source hull
);
    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int AW = 2 * C + 3;
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SNEXT = 5'd1;
    localparam logic [4:0] ST_SLOAD = 5'd2;
    localparam logic [4:0] ST_SCMP  = 5'd3;
    localparam logic [4:0] ST_SCMP1 = 5'd4;
    localparam logic [4:0] ST_SCMP2 = 5'd5;
    localparam logic [4:0] ST_MAC0  = 5'd6;
    localparam logic [4:0] ST_MAC1  = 5'd7;
    localparam logic [4:0] ST_MAC2  = 5'd8;
    localparam logic [4:0] ST_MAC3  = 5'd9;
    localparam logic [4:0] ST_MAC4  = 5'd10;
    localparam logic [4:0] ST_MAC5  = 5'd11;
    localparam logic [4:0] ST_MAC6  = 5'd12;
    localparam logic [4:0] ST_SINS  = 5'd13;
    localparam logic [4:0] ST_H0    = 5'd14;
    localparam logic [4:0] ST_H1    = 5'd15;
    localparam logic [4:0] ST_H2    = 5'd16;
    localparam logic [4:0] ST_HK    = 5'd17;
    localparam logic [4:0] ST_HK1   = 5'd18;
    localparam logic [4:0] ST_HK2   = 5'd19;
    localparam logic [4:0] ST_HDIF  = 5'd20;
    localparam logic [4:0] ST_POP1  = 5'd21;
    localparam logic [4:0] ST_POP2  = 5'd22;
    localparam logic [4:0] ST_E1    = 5'd23;
    localparam logic [4:0] ST_E2    = 5'd24;
    localparam logic [4:0] ST_E3    = 5'd25;
    localparam logic [4:0] ST_E4    = 5'd26;

    // memories
    logic [2*C-1:0] pt_mem  [MAX_POINTS];
    logic [IW-1:0]  so_mem  [MAX_POINTS];
    logic [IW-1:0]  stk_mem [MAX_POINTS];
    logic [2*C-1:0] pt_q;
    logic [IW-1:0]  so_q;
    logic [IW-1:0]  stk_q;
    logic [IW-1:0]  pt_raddr, so_raddr, stk_raddr, so_waddr, stk_waddr;
    logic [IW-1:0]  so_wdata, stk_wdata;
    logic           pt_we, so_we, stk_we;
    logic signed [C-1:0] qx, qy;

    // control
    logic [4:0]    state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [IW-1:0] m_reg, m_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] e_reg, e_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic [IW-1:0] piv_reg, piv_next;
    logic          scan_reg, scan_next;
    logic          hvalid_reg, hvalid_next;

    // datapath
    logic signed [C-1:0]  px_reg, px_next, py_reg, py_next;
    logic signed [C-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [C-1:0]  tx_reg, tx_next, ty_reg, ty_next;
    logic signed [C-1:0]  bx_reg, bx_next, by_reg, by_next;
    logic signed [DW-1:0] dxa_reg, dxa_next, dya_reg, dya_next;
    logic signed [DW-1:0] dxb_reg, dxb_next, dyb_reg, dyb_next;
    logic signed [AW-1:0] da_reg, da_next, db_reg, db_next;
    logic [IW-1:0]        s_reg, s_next, cand_reg, cand_next;
    logic signed [C-1:0]  hx_reg, hx_next, hy_reg, hy_next;
    logic                 hlast_reg, hlast_next;

    mac_op_t              mac_op;
    logic signed [DW-1:0] mac_a, mac_b;
    logic signed [AW-1:0] acc;
    logic                 acc_neg, acc_zero, before_ok, in_acc;

    chull_mac #(.OPW(DW), .AW(AW)) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (acc)
    );

    assign qx = $signed(pt_q[2*C-1:C]);
    assign qy = $signed(pt_q[C-1:0]);

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[n_reg[IW-1:0]] <= {pts.point_x, pts.point_y};
        end
        pt_q <= pt_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (so_we)
        begin
            so_mem[so_waddr] <= so_wdata;
        end
        so_q <= so_mem[so_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_q <= stk_mem[stk_raddr];
    end

    assign acc_neg  = acc[AW-1];
    assign acc_zero = (acc == '0);
    // candidate goes before the other point around the pivot
    assign before_ok = (da_reg == '0 || db_reg == '0) ? (da_reg < db_reg) :
                       (!acc_zero ? !acc_neg : (da_reg < db_reg));
    assign in_acc    = pts.valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        m_next      = m_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        e_next      = e_reg;
        depth_next  = depth_reg;
        piv_next    = piv_reg;
        scan_next   = scan_reg;
        hvalid_next = hvalid_reg;
        px_next = px_reg;   py_next = py_reg;
        cx_next = cx_reg;   cy_next = cy_reg;
        tx_next = tx_reg;   ty_next = ty_reg;
        bx_next = bx_reg;   by_next = by_reg;
        dxa_next = dxa_reg; dya_next = dya_reg;
        dxb_next = dxb_reg; dyb_next = dyb_reg;
        da_next = da_reg;   db_next = db_reg;
        s_next = s_reg;     cand_next = cand_reg;
        hx_next = hx_reg;   hy_next = hy_reg;   hlast_next = hlast_reg;
        pt_we = 1'b0;  so_we = 1'b0;  stk_we = 1'b0;
        pt_raddr  = '0;
        so_raddr  = '0;
        stk_raddr = '0;
        so_waddr  = j_reg;
        so_wdata  = s_reg;
        stk_waddr = '0;
        stk_wdata = piv_reg;
        mac_op = MAC_HOLD;
        mac_a  = dxa_reg;
        mac_b  = dxa_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (n_reg < CW'(MAX_POINTS))
                    begin
                        pt_we  = 1'b1;
                        n_next = n_reg + 1'b1;
                        if (n_reg == '0 || pts.point_y < py_reg ||
                            (pts.point_y == py_reg && pts.point_x < px_reg))
                        begin
                            piv_next = n_reg[IW-1:0];
                            px_next  = pts.point_x;
                            py_next  = pts.point_y;
                        end
                    end
                    if (pts.final_point)
                    begin
                        i_next     = '0;
                        m_next     = '0;
                        scan_next  = 1'b0;
                        state_next = ST_SNEXT;
                    end
                end
            end
            ST_SNEXT:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = ST_H0;
                end
                else if (i_reg[IW-1:0] == piv_reg)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    pt_raddr   = i_reg[IW-1:0];
                    state_next = ST_SLOAD;
                end
            end
            ST_SLOAD:
            begin
                cx_next    = qx;
                cy_next    = qy;
                j_next     = m_reg;
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                if (j_reg == '0)
                begin
                    state_next = ST_SINS;
                end
                else
                begin
                    so_raddr   = j_reg - 1'b1;
                    state_next = ST_SCMP1;
                end
            end
            ST_SCMP1:
            begin
                pt_raddr   = so_q;
                s_next     = so_q;
                state_next = ST_SCMP2;
            end
            ST_SCMP2:
            begin
                dxa_next   = DW'(cx_reg) - DW'(px_reg);
                dya_next   = DW'(cy_reg) - DW'(py_reg);
                dxb_next   = DW'(qx) - DW'(px_reg);
                dyb_next   = DW'(qy) - DW'(py_reg);
                state_next = ST_MAC0;
            end
            ST_MAC0:
            begin
                mac_op = MAC_LOAD; mac_a = dxa_reg; mac_b = dxa_reg;
                state_next = ST_MAC1;
            end
            ST_MAC1:
            begin
                mac_op = MAC_ADD; mac_a = dya_reg; mac_b = dya_reg;
                state_next = ST_MAC2;
            end
            ST_MAC2:
            begin
                da_next = acc;
                mac_op = MAC_LOAD; mac_a = dxb_reg; mac_b = dxb_reg;
                state_next = ST_MAC3;
            end
            ST_MAC3:
            begin
                mac_op = MAC_ADD; mac_a = dyb_reg; mac_b = dyb_reg;
                state_next = ST_MAC4;
            end
            ST_MAC4:
            begin
                db_next = acc;
                mac_op = MAC_LOAD; mac_a = dxa_reg; mac_b = dyb_reg;
                state_next = ST_MAC5;
            end
            ST_MAC5:
            begin
                mac_op = MAC_SUB; mac_a = dya_reg; mac_b = dxb_reg;
                state_next = ST_MAC6;
            end
            ST_MAC6:
            begin
                if (!scan_reg)
                begin
                    if (before_ok)
                    begin
                        // shift the compared entry up one slot
                        so_we      = 1'b1;
                        so_waddr   = j_reg;
                        so_wdata   = s_reg;
                        j_next     = j_reg - 1'b1;
                        state_next = ST_SCMP;
                    end
                    else
                    begin
                        state_next = ST_SINS;
                    end
                end
                else if (acc_neg && depth_reg > CW'(2))
                begin
                    tx_next    = bx_reg;
                    ty_next    = by_reg;
                    depth_next = depth_reg - 1'b1;
                    stk_raddr  = IW'(depth_reg - CW'(3));
                    state_next = ST_POP1;
                end
                else if (acc_zero)
                begin
                    // collinear: keep the farther one
                    if (db_reg > da_reg)
                    begin
                        tx_next   = cx_reg;
                        ty_next   = cy_reg;
                        stk_we    = 1'b1;
                        stk_waddr = IW'(depth_reg - 1'b1);
                        stk_wdata = cand_reg;
                    end
                    k_next     = k_reg + 1'b1;
                    state_next = ST_HK;
                end
                else
                begin
                    bx_next    = tx_reg;
                    by_next    = ty_reg;
                    tx_next    = cx_reg;
                    ty_next    = cy_reg;
                    stk_we     = 1'b1;
                    stk_waddr  = depth_reg[IW-1:0];
                    stk_wdata  = cand_reg;
                    depth_next = depth_reg + 1'b1;
                    k_next     = k_reg + 1'b1;
                    state_next = ST_HK;
                end
            end
            ST_SINS:
            begin
                so_we      = 1'b1;
                so_waddr   = j_reg;
                so_wdata   = i_reg[IW-1:0];
                m_next     = m_reg + 1'b1;
                i_next     = i_reg + 1'b1;
                state_next = ST_SNEXT;
            end
            ST_H0:
            begin
                scan_next  = 1'b1;
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = piv_reg;
                depth_next = CW'(1);
                so_raddr   = '0;
                e_next     = '0;
                state_next = (m_reg == '0) ? ST_E1 : ST_H1;
            end
            ST_H1:
            begin
                pt_raddr   = so_q;
                stk_we     = 1'b1;
                stk_waddr  = IW'(1);
                stk_wdata  = so_q;
                state_next = ST_H2;
            end
            ST_H2:
            begin
                tx_next    = qx;
                ty_next    = qy;
                bx_next    = px_reg;
                by_next    = py_reg;
                depth_next = CW'(2);
                k_next     = IW'(1);
                state_next = ST_HK;
            end
            ST_HK:
            begin
                if (k_reg == m_reg)
                begin
                    e_next     = '0;
                    state_next = ST_E1;
                end
                else
                begin
                    so_raddr   = k_reg;
                    state_next = ST_HK1;
                end
            end
            ST_HK1:
            begin
                pt_raddr   = so_q;
                cand_next  = so_q;
                state_next = ST_HK2;
            end
            ST_HK2:
            begin
                cx_next    = qx;
                cy_next    = qy;
                state_next = ST_HDIF;
            end
            ST_HDIF:
            begin
                dxa_next   = DW'(tx_reg) - DW'(bx_reg);
                dya_next   = DW'(ty_reg) - DW'(by_reg);
                dxb_next   = DW'(cx_reg) - DW'(bx_reg);
                dyb_next   = DW'(cy_reg) - DW'(by_reg);
                state_next = ST_MAC0;
            end
            ST_POP1:
            begin
                pt_raddr   = stk_q;
                state_next = ST_POP2;
            end
            ST_POP2:
            begin
                bx_next    = qx;
                by_next    = qy;
                state_next = ST_HDIF;
            end
            ST_E1:
            begin
                stk_raddr  = e_reg;
                state_next = ST_E2;
            end
            ST_E2:
            begin
                pt_raddr   = stk_q;
                state_next = ST_E3;
            end
            ST_E3:
            begin
                hx_next     = qx;
                hy_next     = qy;
                hlast_next  = (CW'(e_reg) == depth_reg - 1'b1);
                hvalid_next = 1'b1;
                state_next  = ST_E4;
            end
            ST_E4:
            begin
                if (hull.ready)
                begin
                    hvalid_next = 1'b0;
                    if (hlast_reg)
                    begin
                        n_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg + 1'b1;
                        state_next = ST_E1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            n_reg      <= '0;
            i_reg      <= '0;
            m_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            e_reg      <= '0;
            depth_reg  <= '0;
            piv_reg    <= '0;
            scan_reg   <= 1'b0;
            hvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            m_reg      <= m_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            e_reg      <= e_next;
            depth_reg  <= depth_next;
            piv_reg    <= piv_next;
            scan_reg   <= scan_next;
            hvalid_reg <= hvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;   py_reg <= py_next;
        cx_reg <= cx_next;   cy_reg <= cy_next;
        tx_reg <= tx_next;   ty_reg <= ty_next;
        bx_reg <= bx_next;   by_reg <= by_next;
        dxa_reg <= dxa_next; dya_reg <= dya_next;
        dxb_reg <= dxb_next; dyb_reg <= dyb_next;
        da_reg <= da_next;   db_reg <= db_next;
        s_reg <= s_next;     cand_reg <= cand_next;
        hx_reg <= hx_next;   hy_reg <= hy_next;   hlast_reg <= hlast_next;
    end

    assign pts.ready      = (state_reg == ST_IDLE);
    assign hull.valid     = hvalid_reg;
    assign hull.hull_x    = hx_reg;
    assign hull.hull_y    = hy_reg;
    assign hull.hull_last = hlast_reg;
endmodule

>>> sv/chull_chk.sv
// port-level checks for the convex hull block
module chull_chk (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_final,
    input logic out_valid,
    input logic out_ready,
    input logic out_last
);
    // an offered vertex stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("hull item dropped before accept");

    // no new points while vertices are being delivered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while hull output pending");

    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_final |=> !in_ready)
        else $error("input ready right after final point");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid)
        else $error("output after last hull vertex");
endmodule

bind convex_hull_graham_scan_top chull_chk u_chull_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pts.valid),
    .in_ready  (pts.ready),
    .in_final  (pts.final_point),
    .out_valid (hull.valid),
    .out_ready (hull.ready),
    .out_last  (hull.hull_last)
);
